// File: rtl/phvt_pkg.sv
// Shared types and constants for the piezo hit velocity trigger.
package phvt_pkg;

    // Hit detection states, one-hot.
    typedef enum logic [5:0] {
        HIT_UNDER   = 6'b000001,
        HIT_SIGNAL  = 6'b000010,
        HIT_RISING  = 6'b000100,
        HIT_PEAK    = 6'b001000,
        HIT_SEND    = 6'b010000,
        HIT_FALLING = 6'b100000
    } hit_state_t;

    // Controller sequencing states, one-hot.
    typedef enum logic [4:0] {
        CTRL_IDLE     = 5'b00001,
        CTRL_EVAL     = 5'b00010,
        CTRL_DIV      = 5'b00100,
        CTRL_SEND_ON  = 5'b01000,
        CTRL_SEND_OFF = 5'b10000
    } ctrl_state_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_FULL_SCALE = 3'd1;
    localparam logic [2:0] REG_REARM      = 3'd2;
    localparam logic [2:0] REG_NOTE       = 3'd3;
    localparam logic [2:0] REG_CHANNEL    = 3'd4;

    localparam logic [9:0]  THRESHOLD_RST  = 10'd100;
    localparam logic [9:0]  FULL_SCALE_RST = 10'd1023;
    localparam logic [15:0] REARM_RST      = 16'd50;
    localparam logic [6:0]  NOTE_RST       = 7'd60;
    localparam logic [3:0]  CHANNEL_RST    = 4'd0;

    localparam logic [6:0] VEL_MAX    = 7'd127;
    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;
    localparam logic [3:0] CIN_ON     = 4'h9;
    localparam logic [3:0] CIN_OFF    = 4'h8;

    // Number of quotient bits produced by the divider.
    localparam int unsigned QUO_BITS = 7;

    typedef struct packed {
        logic [9:0]  trigger_threshold;
        logic [9:0]  full_scale_level;
        logic [15:0] rearm_delay_ms;
        logic [6:0]  default_note;
        logic [3:0]  midi_channel;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic load_off;
    } cmd_t;

    typedef struct packed {
        logic track;
        logic send;
        logic div_last;
    } sts_t;

endpackage

// File: rtl/phvt_regs.sv
// Configuration register file behind the APB-style port.
module phvt_regs
    import phvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [9:0]  threshold_reg;
    logic [9:0]  full_scale_reg;
    logic [15:0] rearm_reg;
    logic [6:0]  note_reg;
    logic [3:0]  channel_reg;
    logic [2:0]  index;
    logic        write_en;

    assign index    = paddr[4:2];
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            full_scale_reg <= FULL_SCALE_RST;
            rearm_reg      <= REARM_RST;
            note_reg       <= NOTE_RST;
            channel_reg    <= CHANNEL_RST;
        end
        else if (write_en)
        begin
            unique case (index)
                REG_THRESHOLD:  threshold_reg  <= pwdata[9:0];
                REG_FULL_SCALE: full_scale_reg <= pwdata[9:0];
                REG_REARM:      rearm_reg      <= pwdata[15:0];
                REG_NOTE:       note_reg       <= pwdata[6:0];
                REG_CHANNEL:    channel_reg    <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_THRESHOLD:  prdata = {22'd0, threshold_reg};
            REG_FULL_SCALE: prdata = {22'd0, full_scale_reg};
            REG_REARM:      prdata = {16'd0, rearm_reg};
            REG_NOTE:       prdata = {25'd0, note_reg};
            REG_CHANNEL:    prdata = {28'd0, channel_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.trigger_threshold = threshold_reg;
    assign cfg.full_scale_level  = full_scale_reg;
    assign cfg.rearm_delay_ms    = rearm_reg;
    assign cfg.default_note      = note_reg;
    assign cfg.midi_channel      = channel_reg;

endmodule

// File: rtl/phvt_datapath.sv
// Hit detection state, velocity divider and MIDI output registers.
module phvt_datapath
    import phvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [9:0]  sample,
    input  logic [31:0] now_ms,
    input  logic [6:0]  override_note,
    output logic [3:0]  code_index,
    output logic [7:0]  status_byte,
    output logic [6:0]  note_number,
    output logic [6:0]  note_velocity,
    output logic        last
);

    // Captured request.
    logic [9:0]  sample_reg;
    logic [31:0] now_reg;
    logic [6:0]  override_reg;

    // Detector state.
    hit_state_t  hit_reg;
    hit_state_t  hit_next;
    hit_state_t  prior_hit_reg;
    logic [9:0]  prior_sample_reg;
    logic [6:0]  peak_reg;
    logic [31:0] onset_reg;
    logic        pending_reg;

    // Divider.
    logic [16:0] num_reg;
    logic [9:0]  den_reg;
    logic [2:0]  cnt_reg;
    logic [6:0]  quo_reg;
    logic        sat_reg;

    // Result registers.
    logic [3:0]  code_reg;
    logic [7:0]  status_reg;
    logic [6:0]  note_reg;
    logic [6:0]  vel_reg;
    logic        last_reg;

    logic [31:0] elapsed;
    logic [16:0] scaled;
    logic [9:0]  den;
    logic        scale_ok;
    logic        sat_now;
    logic [16:0] shifted;
    logic        ge;
    logic [6:0]  quo_step;
    logic [6:0]  vel;
    logic [6:0]  note_sel;

    assign elapsed  = now_reg - onset_reg;
    // 127 * sample as a shift and a subtract.
    assign scaled   = {sample_reg, 7'd0} - {7'd0, sample_reg};
    assign scale_ok = cfg.full_scale_level > cfg.trigger_threshold;
    assign den      = cfg.full_scale_level - cfg.trigger_threshold;
    // The quotient exceeds 127 exactly when the dividend reaches 128 times the divisor.
    assign sat_now  = !scale_ok || (scaled >= {den, 7'd0});

    always_comb
    begin
        unique case (hit_reg)
            HIT_SIGNAL:
                hit_next = (sample_reg > prior_sample_reg) ? HIT_RISING : HIT_SIGNAL;
            HIT_RISING:
                hit_next = (sample_reg < prior_sample_reg) ? HIT_PEAK : HIT_RISING;
            HIT_PEAK:
                hit_next = pending_reg ? HIT_SEND : HIT_PEAK;
            HIT_SEND:
                hit_next = (prior_hit_reg == HIT_SEND) ? HIT_FALLING : HIT_SEND;
            HIT_FALLING:
                hit_next = (sample_reg < cfg.trigger_threshold
                            && elapsed > {16'd0, cfg.rearm_delay_ms})
                           ? HIT_UNDER : HIT_FALLING;
            default:
                hit_next = (sample_reg > cfg.trigger_threshold
                            && sample_reg > prior_sample_reg)
                           ? HIT_SIGNAL : HIT_UNDER;
        endcase
    end

    assign sts.track    = (hit_next == HIT_SIGNAL) || (hit_next == HIT_RISING);
    assign sts.send     = (hit_next == HIT_SEND);
    assign sts.div_last = (cnt_reg == 3'd0);

    // One restoring shift-subtract step per cycle, most significant bit first.
    assign shifted  = {7'd0, den_reg} << cnt_reg;
    assign ge       = num_reg >= shifted;
    assign quo_step = ge ? (quo_reg | (7'd1 << cnt_reg)) : quo_reg;
    assign vel      = sat_reg ? VEL_MAX : quo_step;
    assign note_sel = (override_reg == 7'd0) ? cfg.default_note : override_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg          <= HIT_UNDER;
            prior_hit_reg    <= HIT_UNDER;
            prior_sample_reg <= 10'd0;
            peak_reg         <= 7'd0;
            onset_reg        <= 32'd0;
            pending_reg      <= 1'b0;
        end
        else if (cmd.eval)
        begin
            hit_reg          <= hit_next;
            prior_hit_reg    <= hit_next;
            prior_sample_reg <= sample_reg;
            if (hit_next == HIT_SIGNAL)
            begin
                onset_reg <= now_reg;
            end
            if (hit_next == HIT_PEAK)
            begin
                pending_reg <= 1'b1;
            end
            if (hit_next == HIT_SEND)
            begin
                pending_reg <= 1'b0;
                peak_reg    <= 7'd0;
            end
        end
        else if (cmd.div_step && sts.div_last && (vel > peak_reg))
        begin
            peak_reg <= vel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg   <= sample;
            now_reg      <= now_ms;
            override_reg <= override_note;
        end

        if (cmd.eval)
        begin
            num_reg <= scaled;
            den_reg <= den;
            cnt_reg <= 3'(QUO_BITS - 1);
            quo_reg <= 7'd0;
            sat_reg <= sat_now;
        end
        else if (cmd.div_step)
        begin
            num_reg <= ge ? (num_reg - shifted) : num_reg;
            quo_reg <= quo_step;
            cnt_reg <= cnt_reg - 3'd1;
        end

        if (cmd.eval && sts.send)
        begin
            code_reg   <= CIN_ON;
            status_reg <= STATUS_ON | {4'd0, cfg.midi_channel};
            note_reg   <= note_sel;
            vel_reg    <= peak_reg;
            last_reg   <= 1'b0;
        end
        else if (cmd.load_off)
        begin
            code_reg   <= CIN_OFF;
            status_reg <= STATUS_OFF | {4'd0, cfg.midi_channel};
            vel_reg    <= 7'd0;
            last_reg   <= 1'b1;
        end
    end

    assign code_index    = code_reg;
    assign status_byte   = status_reg;
    assign note_number   = note_reg;
    assign note_velocity = vel_reg;
    assign last          = last_reg;

    // A note is sent only from the peak state, and falling always follows a send.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && hit_next == HIT_SEND |-> hit_reg == HIT_PEAK || hit_reg == HIT_SEND)
        else $error("send entered from a state other than peak");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && hit_reg == HIT_SEND |-> hit_next == HIT_FALLING)
        else $error("send state did not move on to falling");

endmodule

// File: rtl/phvt_ctrl.sv
// Sequencing state machine: request intake, evaluation, division and result delivery.
module phvt_ctrl
    import phvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.eval     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_off = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = CTRL_EVAL;
                end
            end
            CTRL_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.send)
                    state_next = CTRL_SEND_ON;
                else if (sts.track)
                    state_next = CTRL_DIV;
                else
                    state_next = CTRL_IDLE;
            end
            CTRL_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            CTRL_SEND_ON:
            begin
                if (out_ready)
                begin
                    cmd.load_off = 1'b1;
                    state_next   = CTRL_SEND_OFF;
                end
            end
            CTRL_SEND_OFF:
            begin
                if (out_ready)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == CTRL_IDLE);
    assign out_valid = (state_reg == CTRL_SEND_ON) || (state_reg == CTRL_SEND_OFF);

    // The note-off always follows an accepted note-on.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTRL_SEND_ON && out_ready |=> state_reg == CTRL_SEND_OFF)
        else $error("note-off did not follow the note-on");

    // Each accepted request moves on to evaluation, and evaluation is never repeated back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == CTRL_EVAL)
        else $error("accepted request was not evaluated");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTRL_EVAL |=> state_reg != CTRL_EVAL)
        else $error("evaluation repeated");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !sts.send || state_reg == CTRL_DIV)
        else $error("divider stepped outside the divide state");

endmodule

// File: rtl/piezo_hit_velocity_trigger.sv
// Piezo hit velocity trigger: top level tying registers, controller and datapath.
// A request is evaluated in the cycle after acceptance; a quiet sample then returns to idle, while
// a sample that tracks velocity first runs the 7-step shift-subtract divider. On a note the note-on
// is valid once evaluation has loaded it and is held until taken; the note-off is valid in the cycle
// after the note-on is taken. A new request is taken only once the previous one is finished, with the
// divider and the two result handshakes on a note. rst_n resets the controller and detector state and
// loads register defaults; the request, divider and output registers have no reset.
module piezo_hit_velocity_trigger
    import phvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  sample,
    input  logic [31:0] now_ms,
    input  logic [6:0]  override_note,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  code_index,
    output logic [7:0]  status_byte,
    output logic [6:0]  note_number,
    output logic [6:0]  note_velocity,
    output logic        last
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    phvt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    phvt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample),
        .now_ms        (now_ms),
        .override_note (override_note),
        .code_index    (code_index),
        .status_byte   (status_byte),
        .note_number   (note_number),
        .note_velocity (note_velocity),
        .last          (last)
    );

endmodule
